>>> design/lbpg_pkg.sv
// ----------------------------------------------------------------------------
// lbpg_pkg
// Shared types, constants and the breathe envelope table for the LED
// blink/breathe pattern generator.
// ----------------------------------------------------------------------------
package lbpg_pkg;

	localparam int PHASE_BITS     = 10;
	localparam int DEFAULT_PERIOD = 1000;

	localparam int ENV_DEPTH = 1 << PHASE_BITS;
	localparam int ENV_W     = 17;
	localparam int DIV_CNT_W = $clog2(PHASE_BITS);

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	localparam longint ONE_Q30           = 64'sd1 << 30;
	localparam longint unsigned PI_Q31   = 64'd6746518852;
	localparam longint unsigned TAYLOR_DIV [10] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182, 64'd240, 64'd306, 64'd380
	};

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_SOLID   = 2'd1,
		MODE_BLINK   = 2'd2,
		MODE_BREATHE = 2'd3
	} lbpg_mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODE    = 3'd0,
		REG_PEAK    = 3'd1,
		REG_PULSES  = 3'd2,
		REG_ON      = 3'd3,
		REG_OFF     = 3'd4,
		REG_GAP     = 3'd5,
		REG_PERIOD  = 3'd6,
		REG_ACT_LOW = 3'd7
	} lbpg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRAIN,
		ST_CYCLE,
		ST_WRAP,
		ST_DIV,
		ST_ROM,
		ST_MUL,
		ST_SQUARE,
		ST_FINISH
	} lbpg_state_t;

	typedef struct packed {
		logic start;
		logic train;
		logic cycle;
		logic wrap;
		logic div_step;
		logic rom;
		logic mul;
		logic square;
		logic load_out;
	} lbpg_cmd_t;

	typedef struct packed {
		logic div_last;
	} lbpg_status_t;

	typedef logic [ENV_W-1:0] env_word_t;
	typedef env_word_t env_table_t [ENV_DEPTH];

	// cos(2*pi*j/2^PHASE_BITS) in Q30 on the quarter wave
	function automatic longint quarter_cos(input int unsigned j);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x = (longint'(j) * PI_Q31) >> PHASE_BITS;
		x2 = (x * x) >> 30;
		term = longint'(ONE_Q30);
		sum = ONE_Q30;
		for (int k = 1; k <= 10; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return sum;
	endfunction

	function automatic env_word_t envelope(input int unsigned idx_in);
		int unsigned idx;
		int unsigned half;
		longint c;
		longint om;
		longint unsigned r;
		half = ENV_DEPTH / 2;
		idx = idx_in % ENV_DEPTH;
		if (idx > half) begin
			idx = ENV_DEPTH - idx;
		end
		if (idx <= ENV_DEPTH / 4) begin
			c = quarter_cos(idx);
		end else begin
			c = -quarter_cos(half - idx);
		end
		om = ONE_Q30 - c;
		if (om < 0) begin
			om = 0;
		end
		if (om > 2 * ONE_Q30) begin
			om = 2 * ONE_Q30;
		end
		r = ((longint'(om) << 16) + (64'd1 << 30)) >> 31;
		return r[ENV_W-1:0];
	endfunction

	function automatic env_table_t env_table();
		env_table_t t;
		for (int i = 0; i < ENV_DEPTH; i++) begin
			t[i] = envelope(i);
		end
		return t;
	endfunction

endpackage

>>> design/lbpg_env_rom.sv
// ----------------------------------------------------------------------------
// lbpg_env_rom
// Raised-cosine breathe envelope, Q0.16 with 17 bits, registered read.
// ----------------------------------------------------------------------------
module lbpg_env_rom (
	input  logic                                  clk,
	input  logic                                  rd_en,
	input  logic [lbpg_pkg::PHASE_BITS-1:0]       addr,
	output logic [lbpg_pkg::ENV_W-1:0]            data
);

	localparam lbpg_pkg::env_table_t ENV_ROM = lbpg_pkg::env_table();

	logic [lbpg_pkg::ENV_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= ENV_ROM[addr];
		end
	end

	assign data = data_q;

endmodule

>>> design/lbpg_datapath.sv
// ----------------------------------------------------------------------------
// lbpg_datapath
// Config registers, pattern positions, bit-serial phase divider, envelope
// lookup, brightness and duty computation, result register.
// ----------------------------------------------------------------------------
module lbpg_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [lbpg_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [lbpg_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                   restart,
	input  lbpg_pkg::lbpg_cmd_t                    cmd,
	output lbpg_pkg::lbpg_status_t                 status,
	output logic [7:0]                             brightness,
	output logic [7:0]                             duty
);

	localparam int PB = lbpg_pkg::PHASE_BITS;

	lbpg_pkg::lbpg_mode_t mode_q;
	logic [7:0]  peak_q;
	logic [7:0]  pulses_q;
	logic [15:0] on_q;
	logic [15:0] off_q;
	logic [15:0] gap_q;
	logic [15:0] bperiod_q;
	logic        act_low_q;

	logic [25:0] cycle_pos_q;
	logic [16:0] slot_pos_q;
	logic [15:0] breathe_pos_q;

	logic [16:0] slot_q;
	logic [15:0] period_q;
	logic [24:0] train_q;
	logic [25:0] cycle_q;

	logic [15:0]                          rem_q;
	logic [PB-1:0]                        quot_q;
	logic [lbpg_pkg::DIV_CNT_W-1:0]       div_cnt_q;
	logic [lbpg_pkg::ENV_W-1:0]           env;

	logic [7:0]  bright_q;
	logic [15:0] sq_q;
	logic [7:0]  brightness_q;
	logic [7:0]  duty_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= lbpg_pkg::MODE_OFF;
			peak_q    <= '0;
			pulses_q  <= '0;
			on_q      <= '0;
			off_q     <= '0;
			gap_q     <= '0;
			bperiod_q <= '0;
			act_low_q <= 1'b0;
		end else if (cfg_we) begin
			case (lbpg_pkg::lbpg_reg_t'(cfg_index))
				lbpg_pkg::REG_MODE:    mode_q    <= lbpg_pkg::lbpg_mode_t'(cfg_wdata[1:0]);
				lbpg_pkg::REG_PEAK:    peak_q    <= cfg_wdata[7:0];
				lbpg_pkg::REG_PULSES:  pulses_q  <= cfg_wdata[7:0];
				lbpg_pkg::REG_ON:      on_q      <= cfg_wdata;
				lbpg_pkg::REG_OFF:     off_q     <= cfg_wdata;
				lbpg_pkg::REG_GAP:     gap_q     <= cfg_wdata;
				lbpg_pkg::REG_PERIOD:  bperiod_q <= cfg_wdata;
				lbpg_pkg::REG_ACT_LOW: act_low_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// clamp, lit and advance
	logic [25:0] cycle_pos_c;
	logic [16:0] slot_pos_c;
	logic [15:0] breathe_pos_c;
	logic [26:0] cycle_pos_inc;
	logic [17:0] slot_pos_inc;
	logic [16:0] breathe_pos_inc;
	logic        lit;
	logic [7:0]  bright_d;
	logic [24:0] env_prod;
	logic [16:0] div_shift;
	logic        div_ge;

	always_comb begin
		cycle_pos_c   = (cycle_pos_q >= cycle_q) ? '0 : cycle_pos_q;
		slot_pos_c    = (slot_pos_q >= slot_q) ? '0 : slot_pos_q;
		breathe_pos_c = (breathe_pos_q >= period_q) ? '0 : breathe_pos_q;

		cycle_pos_inc   = {1'b0, cycle_pos_q} + 27'd1;
		slot_pos_inc    = {1'b0, slot_pos_q} + 18'd1;
		breathe_pos_inc = {1'b0, breathe_pos_q} + 17'd1;

		lit = ({1'b0, cycle_pos_q} < {2'b00, train_q}) && (slot_q != '0)
			&& (slot_pos_q < {1'b0, on_q});

		env_prod = {17'd0, peak_q} * {8'd0, env};

		case (mode_q)
			lbpg_pkg::MODE_SOLID:   bright_d = peak_q;
			lbpg_pkg::MODE_BLINK:   bright_d = (cycle_q == '0 || lit) ? peak_q : 8'd0;
			lbpg_pkg::MODE_BREATHE: bright_d = env_prod[23:16];
			default:                bright_d = 8'd0;
		endcase

		div_shift = {rem_q, 1'b0};
		div_ge    = div_shift >= {1'b0, period_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_pos_q   <= '0;
			slot_pos_q    <= '0;
			breathe_pos_q <= '0;
		end else if (cmd.start) begin
			if (restart) begin
				cycle_pos_q   <= '0;
				slot_pos_q    <= '0;
				breathe_pos_q <= '0;
			end
		end else if (cmd.wrap) begin
			cycle_pos_q   <= cycle_pos_c;
			slot_pos_q    <= slot_pos_c;
			breathe_pos_q <= breathe_pos_c;
		end else if (cmd.mul) begin
			if (cycle_q != '0) begin
				if (cycle_pos_inc >= {1'b0, cycle_q}) begin
					cycle_pos_q <= '0;
					slot_pos_q  <= '0;
				end else begin
					cycle_pos_q <= cycle_pos_inc[25:0];
					if (slot_q != '0) begin
						slot_pos_q <= (slot_pos_inc >= {1'b0, slot_q}) ? '0 : slot_pos_inc[16:0];
					end
				end
			end else begin
				cycle_pos_q <= '0;
				slot_pos_q  <= '0;
			end
			breathe_pos_q <= (breathe_pos_inc >= {1'b0, period_q}) ? '0 : breathe_pos_inc[15:0];
		end
	end

	// lengths, divider and arithmetic
	logic [24:0] sq_x257;
	logic [8:0]  q_est;
	logic [16:0] q_back;
	logic [16:0] q_rem;
	logic [7:0]  q_fix;
	logic [7:0]  duty_d;

	always_comb begin
		sq_x257 = {1'b0, sq_q, 8'd0} + {9'd0, sq_q};
		q_est   = {1'b0, sq_x257[23:16]};
		q_back  = {q_est, 8'd0} - {8'd0, q_est};
		q_rem   = {1'b0, sq_q} - q_back;
		q_fix   = (q_rem >= 17'd255) ? (q_est[7:0] + 8'd1) : q_est[7:0];
		duty_d  = act_low_q ? (8'd255 - q_fix) : q_fix;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			slot_q   <= {1'b0, on_q} + {1'b0, off_q};
			period_q <= (bperiod_q == '0) ? 16'(lbpg_pkg::DEFAULT_PERIOD) : bperiod_q;
		end
		if (cmd.train) begin
			train_q <= {17'd0, pulses_q} * {8'd0, slot_q};
		end
		if (cmd.cycle) begin
			cycle_q <= {1'b0, train_q} + {10'd0, gap_q};
		end
		if (cmd.wrap) begin
			rem_q     <= breathe_pos_c;
			quot_q    <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= div_ge ? 16'(div_shift - {1'b0, period_q}) : div_shift[15:0];
			quot_q    <= {quot_q[PB-2:0], div_ge};
			div_cnt_q <= div_cnt_q + lbpg_pkg::DIV_CNT_W'(1);
		end
		if (cmd.mul) begin
			bright_q <= bright_d;
		end
		if (cmd.square) begin
			sq_q <= {8'd0, bright_q} * {8'd0, bright_q};
		end
		if (cmd.load_out) begin
			brightness_q <= bright_q;
			duty_q       <= duty_d;
		end
	end

	lbpg_env_rom u_env_rom (
		.clk   (clk),
		.rd_en (cmd.rom),
		.addr  (quot_q),
		.data  (env)
	);

	assign status.div_last = (div_cnt_q == lbpg_pkg::DIV_CNT_W'(PB - 1));
	assign brightness      = brightness_q;
	assign duty            = duty_q;

endmodule

>>> design/lbpg_ctrl.sv
// ----------------------------------------------------------------------------
// lbpg_ctrl
// Sequencer for one tick: lengths, position wrap, phase division, envelope
// lookup, brightness, squaring, and the result handshake.
// ----------------------------------------------------------------------------
module lbpg_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  lbpg_pkg::lbpg_status_t   status,
	output lbpg_pkg::lbpg_cmd_t      cmd
);

	lbpg_pkg::lbpg_state_t state_q;
	lbpg_pkg::lbpg_state_t state_d;
	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lbpg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			lbpg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = lbpg_pkg::ST_TRAIN;
				end
			end
			lbpg_pkg::ST_TRAIN: begin
				cmd.train = 1'b1;
				state_d   = lbpg_pkg::ST_CYCLE;
			end
			lbpg_pkg::ST_CYCLE: begin
				cmd.cycle = 1'b1;
				state_d   = lbpg_pkg::ST_WRAP;
			end
			lbpg_pkg::ST_WRAP: begin
				cmd.wrap = 1'b1;
				state_d  = lbpg_pkg::ST_DIV;
			end
			lbpg_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = lbpg_pkg::ST_ROM;
				end
			end
			lbpg_pkg::ST_ROM: begin
				cmd.rom = 1'b1;
				state_d = lbpg_pkg::ST_MUL;
			end
			lbpg_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = lbpg_pkg::ST_SQUARE;
			end
			lbpg_pkg::ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = lbpg_pkg::ST_FINISH;
			end
			lbpg_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = lbpg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lbpg_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/led_blink_breathe_pattern_generator.sv
// ----------------------------------------------------------------------------
// led_blink_breathe_pattern_generator
// One request per millisecond tick gives a linear LED brightness and a
// gamma-squared PWM duty for off, solid, blink or breathe patterns. The
// phase index of a tick comes from the bit-serial phase divider, which gives
// one index bit per cycle; the finished result sits in an output register,
// so the next request is taken while it waits. Config registers are to be
// written through cfg_we/cfg_index/cfg_wdata only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module led_blink_breathe_pattern_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lbpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lbpg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          brightness,
	output logic [7:0]                          duty
);

	lbpg_pkg::lbpg_cmd_t    cmd;
	lbpg_pkg::lbpg_status_t status;

	lbpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lbpg_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.restart    (restart),
		.cmd        (cmd),
		.status     (status),
		.brightness (brightness),
		.duty       (duty)
	);

endmodule

>>> tb/tb_led_blink_breathe_pattern_generator.sv
// ----------------------------------------------------------------------------
// tb_led_blink_breathe_pattern_generator
// Self-checking bench for the LED blink/breathe pattern generator. A short
// table of ticks and register writes covers off, solid, blink and breathe,
// zero-length cycles and slots, extreme times and shrinking lengths. Random
// register settings with random tick trains follow. Every request is predicted
// by an in-bench model of the positions and raised-cosine envelope, or by
// fixed table levels on chk rows; results are compared in order with these.
// ----------------------------------------------------------------------------
module tb_led_blink_breathe_pattern_generator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENV_N        = 1 << lbpg_pkg::PHASE_BITS;
	localparam int RAND_ITEMS   = 400;
	localparam int SETTLE       = 24;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DIR_ROWS     = 52;
	localparam longint UNIT_Q30 = 64'sd1 << 30;
	localparam longint unsigned PI_Q31_K = 64'd6746518852;

	typedef struct packed {
		logic [7:0] bright;
		logic [7:0] duty;
	} led_level_t;

	typedef struct packed {
		logic                wr;
		lbpg_pkg::lbpg_reg_t idx;
		logic [15:0]         val;
		logic                rs;
		logic                chk;
		logic [7:0]          bright;
		logic [7:0]          duty;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [lbpg_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [lbpg_pkg::CFG_DATA_W-1:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        restart;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  brightness;
	logic [7:0]  duty;

	// register copies and pattern positions
	lbpg_pkg::lbpg_mode_t cfg_mode;
	logic [7:0]  cfg_peak;
	logic [7:0]  cfg_pulses;
	logic [15:0] cfg_on;
	logic [15:0] cfg_off;
	logic [15:0] cfg_gap;
	logic [15:0] cfg_period;
	logic        cfg_act_low;
	logic [25:0] cyc_pos;
	logic [16:0] slot_pos;
	logic [15:0] breath_pos;
	logic [16:0] env_rom [ENV_N];

	led_level_t  pending_levels [$];
	led_level_t  seen_front;
	int          mismatch_cnt;
	int          cycle_cnt;
	int          send_idle;
	int          recv_idle;
	bit          hold_out;

	step_row_t dir_tab [DIR_ROWS] = '{
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b1, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_ACT_LOW, 16'd1,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b1, 8'd0,   8'd255},
		'{1'b1, lbpg_pkg::REG_MODE,    16'(lbpg_pkg::MODE_SOLID), 1'b0, 1'b0, 8'd0, 8'd0},
		'{1'b1, lbpg_pkg::REG_PEAK,    16'd255,   1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b1, 8'd255, 8'd0},
		'{1'b1, lbpg_pkg::REG_ACT_LOW, 16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b1, 8'd255, 8'd255},
		'{1'b1, lbpg_pkg::REG_PEAK,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b1, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_MODE,    16'(lbpg_pkg::MODE_BLINK), 1'b0, 1'b0, 8'd0, 8'd0},
		'{1'b1, lbpg_pkg::REG_PEAK,    16'd128,   1'b0, 1'b0, 8'd0,   8'd0},
		// zero cycle length gives a steady level
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b1, 8'd128, 8'd64},
		'{1'b1, lbpg_pkg::REG_PULSES,  16'd2,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_ON,      16'd1,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_OFF,     16'd1,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_GAP,     16'd2,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b1, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		// zero slot length, never lit
		'{1'b1, lbpg_pkg::REG_ON,      16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_OFF,     16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_ON,      16'hFFFF,  1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_OFF,     16'hFFFF,  1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_PULSES,  16'd255,   1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_GAP,     16'hFFFF,  1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		// shrink the cycle below the current positions
		'{1'b1, lbpg_pkg::REG_PULSES,  16'd1,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_ON,      16'd1,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_OFF,     16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_GAP,     16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_MODE,    16'(lbpg_pkg::MODE_BREATHE), 1'b0, 1'b0, 8'd0, 8'd0},
		'{1'b1, lbpg_pkg::REG_PEAK,    16'd255,   1'b0, 1'b0, 8'd0,   8'd0},
		// zero period means the default period
		'{1'b1, lbpg_pkg::REG_PERIOD,  16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b1, 1'b1, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_PERIOD,  16'hFFFF,  1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_PERIOD,  16'd1,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b1, 8'd0,   8'd0},
		'{1'b1, lbpg_pkg::REG_PERIOD,  16'd2,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0},
		'{1'b0, lbpg_pkg::REG_MODE,    16'd0,     1'b0, 1'b0, 8'd0,   8'd0}
	};

	led_blink_breathe_pattern_generator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.brightness (brightness),
		.duty       (duty)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// cosine of 2*pi*j/ENV_N in Q30, quarter wave, Taylor series
	function automatic longint cos_q30(input int unsigned j);
		longint unsigned ang;
		longint unsigned ang2;
		longint unsigned t;
		longint acc;
		ang = (64'(j) * PI_Q31_K) >> lbpg_pkg::PHASE_BITS;
		ang2 = (ang * ang) >> 30;
		t = 64'(UNIT_Q30);
		acc = UNIT_Q30;
		for (int k = 1; k <= 10; k++) begin
			t = ((t * ang2) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				acc = acc - longint'(t);
			end else begin
				acc = acc + longint'(t);
			end
		end
		return acc;
	endfunction

	// raised cosine (1 - cos)/2 in Q0.16, peak 65536
	function automatic logic [16:0] env_q16(input int unsigned idx_in);
		int unsigned fold;
		longint c;
		longint om;
		longint unsigned r;
		fold = idx_in % ENV_N;
		if (fold > ENV_N / 2) begin
			fold = ENV_N - fold;
		end
		if (fold <= ENV_N / 4) begin
			c = cos_q30(fold);
		end else begin
			c = -cos_q30(ENV_N / 2 - fold);
		end
		om = UNIT_Q30 - c;
		if (om < 0) begin
			om = 0;
		end
		if (om > 2 * UNIT_Q30) begin
			om = 2 * UNIT_Q30;
		end
		r = ((64'(om) << 16) + (64'd1 << 30)) >> 31;
		return r[16:0];
	endfunction

	function automatic void led_model_tick(input logic rs, output logic [7:0] b,
			output logic [7:0] d);
		logic [16:0] slot_len;
		logic [25:0] train_len;
		logic [25:0] cycle_len;
		logic [16:0] per;
		int unsigned pidx;
		int unsigned lvl;
		int unsigned sq;
		logic lit;
		slot_len = 17'(cfg_on) + 17'(cfg_off);
		train_len = 26'(cfg_pulses) * 26'(slot_len);
		cycle_len = train_len + 26'(cfg_gap);
		per = (cfg_period == 16'd0) ? 17'(lbpg_pkg::DEFAULT_PERIOD) : 17'(cfg_period);
		if (rs) begin
			cyc_pos = '0;
			slot_pos = '0;
			breath_pos = '0;
		end
		if (cyc_pos >= cycle_len) cyc_pos = '0;
		if (slot_pos >= slot_len) slot_pos = '0;
		if (17'(breath_pos) >= per) breath_pos = '0;
		lvl = 0;
		case (cfg_mode)
			lbpg_pkg::MODE_SOLID: begin
				lvl = cfg_peak;
			end
			lbpg_pkg::MODE_BLINK: begin
				if (cycle_len == 26'd0) begin
					lvl = cfg_peak;
				end else begin
					lit = (cyc_pos < train_len) && (slot_len != 17'd0) &&
						(slot_pos < 17'(cfg_on));
					lvl = lit ? cfg_peak : 0;
				end
			end
			lbpg_pkg::MODE_BREATHE: begin
				pidx = (32'(breath_pos) << lbpg_pkg::PHASE_BITS) / 32'(per);
				lvl = (32'(cfg_peak) * 32'(env_rom[pidx])) >> 16;
			end
			default: begin
				lvl = 0;
			end
		endcase
		b = lvl[7:0];
		sq = (32'(b) * 32'(b)) / 255;
		d = cfg_act_low ? 8'(255 - sq) : sq[7:0];
		if (cycle_len != 26'd0) begin
			cyc_pos = cyc_pos + 26'd1;
			if (cyc_pos >= cycle_len) begin
				cyc_pos = '0;
				slot_pos = '0;
			end else if (slot_len != 17'd0) begin
				slot_pos = slot_pos + 17'd1;
				if (slot_pos >= slot_len) slot_pos = '0;
			end
		end else begin
			cyc_pos = '0;
			slot_pos = '0;
		end
		breath_pos = breath_pos + 16'd1;
		if (17'(breath_pos) >= per) breath_pos = '0;
	endfunction

	function automatic logic [15:0] rand_reg_val(input lbpg_pkg::lbpg_reg_t r);
		int unsigned p;
		p = $urandom_range(0, 9);
		case (r)
			lbpg_pkg::REG_MODE: begin
				if (p < 1) return 16'(lbpg_pkg::MODE_OFF);
				if (p < 2) return 16'(lbpg_pkg::MODE_SOLID);
				if (p < 6) return 16'(lbpg_pkg::MODE_BLINK);
				return 16'(lbpg_pkg::MODE_BREATHE);
			end
			lbpg_pkg::REG_PEAK: begin
				if (p < 2) return 16'd255;
				if (p < 3) return 16'd0;
				return 16'($urandom);
			end
			lbpg_pkg::REG_PULSES: begin
				if (p < 1) return 16'd255;
				return 16'($urandom_range(0, 4));
			end
			lbpg_pkg::REG_ON, lbpg_pkg::REG_OFF, lbpg_pkg::REG_GAP: begin
				if (p < 1) return 16'hFFFF;
				if (p < 2) return 16'($urandom);
				return 16'($urandom_range(0, 6));
			end
			lbpg_pkg::REG_PERIOD: begin
				if (p < 1) return 16'd0;
				if (p < 2) return 16'hFFFF;
				if (p < 3) return 16'($urandom);
				return 16'($urandom_range(1, 40));
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic write_reg(input lbpg_pkg::lbpg_reg_t r, input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		case (r)
			lbpg_pkg::REG_MODE:    cfg_mode = lbpg_pkg::lbpg_mode_t'(v[1:0]);
			lbpg_pkg::REG_PEAK:    cfg_peak = v[7:0];
			lbpg_pkg::REG_PULSES:  cfg_pulses = v[7:0];
			lbpg_pkg::REG_ON:      cfg_on = v;
			lbpg_pkg::REG_OFF:     cfg_off = v;
			lbpg_pkg::REG_GAP:     cfg_gap = v;
			lbpg_pkg::REG_PERIOD:  cfg_period = v;
			lbpg_pkg::REG_ACT_LOW: cfg_act_low = v[0];
			default:               ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(input logic rs, input logic chk, input logic [7:0] b_fix,
			input logic [7:0] d_fix);
		logic [7:0] pb;
		logic [7:0] pd;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		led_model_tick(rs, pb, pd);
		if (chk) begin
			pb = b_fix;
			pd = d_fix;
		end
		pending_levels.push_back('{bright: pb, duty: pd});
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// result side
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_out = 1'b0;
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				$error("unexpected result brightness %0d duty %0d", brightness, duty);
				mismatch_cnt++;
			end else begin
				seen_front = pending_levels.pop_front();
				if (brightness !== seen_front.bright) begin
					$error("brightness expected %0d got %0d", seen_front.bright,
						brightness);
					mismatch_cnt++;
				end
				if (duty !== seen_front.duty) begin
					$error("duty expected %0d got %0d", seen_front.duty, duty);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("led_blink_breathe_pattern_generator: mismatch");
			$finish;
		end
	end

	initial begin
		int rand_ticks;
		int n_ticks;
		bit pressure_done;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lbpg_pkg::REG_MODE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		restart = 1'b0;
		hold_out = 1'b0;
		mismatch_cnt = 0;
		cycle_cnt = 0;
		rand_ticks = 0;
		pressure_done = 1'b0;
		cfg_mode = lbpg_pkg::MODE_OFF;
		cfg_peak = '0;
		cfg_pulses = '0;
		cfg_on = '0;
		cfg_off = '0;
		cfg_gap = '0;
		cfg_period = '0;
		cfg_act_low = 1'b0;
		cyc_pos = '0;
		slot_pos = '0;
		breath_pos = '0;
		for (int i = 0; i < ENV_N; i++) begin
			env_rom[i] = env_q16(i);
		end
		send_idle = 23;
		recv_idle = 85;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].wr) begin
				quiesce();
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				send_tick(dir_tab[i].rs, dir_tab[i].chk, dir_tab[i].bright,
					dir_tab[i].duty);
			end
		end

		while (rand_ticks < RAND_ITEMS) begin
			if (rand_ticks >= 2 * RAND_ITEMS / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (rand_ticks >= RAND_ITEMS / 3) begin
				send_idle = 85;
				recv_idle = 23;
			end
			quiesce();
			for (int r = 0; r < 8; r++) begin
				if ($urandom_range(0, 9) < 7) begin
					write_reg(lbpg_pkg::lbpg_reg_t'(r),
						rand_reg_val(lbpg_pkg::lbpg_reg_t'(r)));
				end
			end
			n_ticks = $urandom_range(8, 40);
			// back up the result side while requests keep coming
			if (send_idle == 0 && !pressure_done) begin
				pressure_done = 1'b1;
				hold_out = 1'b1;
				n_ticks = 40;
			end
			for (int t = 0; t < n_ticks; t++) begin
				send_tick($urandom_range(0, 19) == 0, 1'b0, 8'd0, 8'd0);
				rand_ticks++;
			end
		end

		quiesce();
		if (mismatch_cnt == 0) begin
			$display("led_blink_breathe_pattern_generator: match");
		end else begin
			$display("led_blink_breathe_pattern_generator: mismatch");
		end
		$finish;
	end

endmodule
